### rtl/nsl_pkg.sv
// Package for the top-N sorted list: request codes, payload structs and defaults.
`timescale 1ns / 1ps

package nsl_pkg;

  localparam int MAX_ENTRIES_DEF   = 16;
  localparam int PAYLOAD_WIDTH_DEF = 32;
  localparam int KEY_W             = 32;
  localparam int CAP_W             = 5;
  localparam int IDX_W             = 4;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [KEY_W-1:0] new_key;
    logic [31:0]             new_payload;
    logic [IDX_W-1:0]        index;
  } nsl_req_t;

  typedef struct packed {
    logic                    status;
    logic signed [KEY_W-1:0] read_key;
    logic [31:0]             read_payload;
    logic [CAP_W-1:0]        count;
  } nsl_rsp_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] index;
  } nsl_ctrl_t;

endpackage

### rtl/nsl_cell.sv
// One cell of the sorted chain: holds one entry, shifts left or right on request.
`timescale 1ns / 1ps

module nsl_cell #(
  parameter int IDX           = 0,
  parameter int PAYLOAD_WIDTH = nsl_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                             clk,
  input  nsl_pkg::nsl_ctrl_t               ctrl,
  input  logic                             in_range,
  input  logic signed [nsl_pkg::KEY_W-1:0] new_key,
  input  logic [PAYLOAD_WIDTH-1:0]         new_pay,
  input  logic                             left_keep,
  input  logic signed [nsl_pkg::KEY_W-1:0] left_key,
  input  logic [PAYLOAD_WIDTH-1:0]         left_pay,
  input  logic signed [nsl_pkg::KEY_W-1:0] right_key,
  input  logic [PAYLOAD_WIDTH-1:0]         right_pay,
  output logic                             keep,
  output logic signed [nsl_pkg::KEY_W-1:0] key,
  output logic [PAYLOAD_WIDTH-1:0]         pay
);
  import nsl_pkg::*;

  logic signed [KEY_W-1:0]  key_r, key_nxt;
  logic [PAYLOAD_WIDTH-1:0] pay_r, pay_nxt;

  // entry stays put on insert when it lies below the count and ranks at or above the new key
  assign keep = in_range && (key_r >= new_key);

  always_comb begin
    key_nxt = key_r;
    pay_nxt = pay_r;
    if (ctrl.ins && !keep) begin
      if (left_keep) begin
        key_nxt = new_key;
        pay_nxt = new_pay;
      end else begin
        key_nxt = left_key;
        pay_nxt = left_pay;
      end
    end else if (ctrl.rem && (IDX >= int'(ctrl.index))) begin
      key_nxt = right_key;
      pay_nxt = right_pay;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

  assign key = key_r;
  assign pay = pay_r;

endmodule

### rtl/top_n_sorted_list_core.sv
// Top level: chain of entry cells, count and capacity registers, result register.
// A request's result is registered at the accepting edge and shown the next cycle.
// One request per cycle while in_ready is high; every cell compares and shifts in the same cycle.
// in_ready falls only while the result register is full and not being taken.
// Reset (rst_n low, synchronous): count 0, capacity 16, result register empty.
// Entry storage is not cleared; entries beyond the count are never read.
`timescale 1ns / 1ps

module top_n_sorted_list_core #(
  parameter int MAX_ENTRIES   = nsl_pkg::MAX_ENTRIES_DEF,
  parameter int PAYLOAD_WIDTH = nsl_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  nsl_pkg::nsl_req_t             in_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output nsl_pkg::nsl_rsp_t             out_rsp,
  input  logic                          cfg_we,
  input  logic [nsl_pkg::CAP_W-1:0]     cfg_wdata
);
  import nsl_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_ENTRIES);

  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r;
  nsl_rsp_t         out_rsp_r, rsp_nxt;

  logic             in_acc;
  logic [CMP_W-1:0] cnt_ext, cap_ext, eff_cap, idx_ext, new_cnt;
  logic             idx_ok;
  nsl_ctrl_t        ctrl;
  logic [63:0]      pay_ext;
  logic [PAYLOAD_WIDTH-1:0] new_pay;

  logic signed [KEY_W-1:0]  cell_key [MAX_ENTRIES];
  logic [PAYLOAD_WIDTH-1:0] cell_pay [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]   keep_vec;
  logic [MAX_ENTRIES-1:0]   below_cnt;

  logic signed [KEY_W-1:0]  rd_key;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;
  logic [63:0]              rd_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  assign cnt_ext = CMP_W'(cnt_r);
  assign cap_ext = CMP_W'(cap_r);
  assign eff_cap = (cap_ext > MAX_C) ? MAX_C : cap_ext;
  assign idx_ext = CMP_W'(in_req.index);
  assign idx_ok  = idx_ext < cnt_ext;

  assign pay_ext = {32'b0, in_req.new_payload};
  assign new_pay = pay_ext[PAYLOAD_WIDTH-1:0];

  assign ctrl.ins   = in_acc && (req_t'(in_req.req_type) == REQ_INSERT) && (cap_r != '0);
  assign ctrl.rem   = in_acc && (req_t'(in_req.req_type) == REQ_REMOVE) && idx_ok;
  assign ctrl.index = in_req.index;

  genvar g;
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      logic                     lk;
      logic signed [KEY_W-1:0]  lkey, rkey;
      logic [PAYLOAD_WIDTH-1:0] lpay, rpay;

      assign below_cnt[g] = CMP_W'(g) < cnt_ext;

      if (g == 0) begin : g_head
        assign lk   = 1'b1;
        assign lkey = '0;
        assign lpay = '0;
      end else begin : g_mid
        assign lk   = keep_vec[g-1];
        assign lkey = cell_key[g-1];
        assign lpay = cell_pay[g-1];
      end

      if (g == MAX_ENTRIES - 1) begin : g_tail
        assign rkey = cell_key[g];
        assign rpay = cell_pay[g];
      end else begin : g_body
        assign rkey = cell_key[g+1];
        assign rpay = cell_pay[g+1];
      end

      nsl_cell #(
        .IDX           (g),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .in_range  (below_cnt[g]),
        .new_key   (in_req.new_key),
        .new_pay   (new_pay),
        .left_keep (lk),
        .left_key  (lkey),
        .left_pay  (lpay),
        .right_key (rkey),
        .right_pay (rpay),
        .keep      (keep_vec[g]),
        .key       (cell_key[g]),
        .pay       (cell_pay[g])
      );
    end
  endgenerate

  // read select: AND-OR over the cells
  always_comb begin
    rd_key = '0;
    rd_pay = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (i == int'(in_req.index)) begin
        rd_key = rd_key | cell_key[i];
        rd_pay = rd_pay | cell_pay[i];
      end
    end
  end
  assign rd_ext = 64'(rd_pay);

  always_comb begin
    new_cnt = cnt_ext;
    rsp_nxt = '0;
    case (req_t'(in_req.req_type))
      REQ_INSERT: begin
        if ((cap_r != '0) && (cnt_ext < eff_cap)) begin
          new_cnt = cnt_ext + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (idx_ok) begin
          new_cnt = cnt_ext - 1'b1;
        end else begin
          rsp_nxt.status = 1'b1;
        end
      end
      REQ_READ: begin
        if (idx_ok) begin
          rsp_nxt.read_key     = rd_key;
          rsp_nxt.read_payload = rd_ext[31:0];
        end else begin
          rsp_nxt.status = 1'b1;
        end
      end
      REQ_CLEAR: begin
        new_cnt = '0;
      end
      default: begin
        new_cnt = cnt_ext;
      end
    endcase
    rsp_nxt.count = new_cnt[CAP_W-1:0];
    cnt_nxt       = in_acc ? new_cnt[CNT_W-1:0] : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // count never runs past the number of cells
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(cnt_r) <= MAX_C)
    else $error("entry count above cell count");

  // entries that outrank the new key form a prefix of the chain
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (keep_vec & ~{keep_vec[MAX_ENTRIES-2:0], 1'b1}) == '0)
    else $error("chain not sorted");

  // a clear request empties the list
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (req_t'(in_req.req_type) == REQ_CLEAR) |=> (cnt_r == '0))
    else $error("clear left entries");

  // every accepted request leaves a result waiting
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("result lost");

endmodule

### test/top_n_sorted_list_core_tb.sv
// Self-checking testbench for the top-N sorted list core with its own list predictor.
`timescale 1ns / 1ps

module top_n_sorted_list_core_tb;
  import nsl_pkg::*;

  localparam int LIST_DEPTH = MAX_ENTRIES_DEF;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  nsl_req_t in_req;
  logic     out_valid;
  logic     out_ready;
  nsl_rsp_t out_rsp;
  logic     cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  top_n_sorted_list_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted list contents, best first
  logic signed [KEY_W-1:0] list_key [LIST_DEPTH];
  logic [31:0]             list_pay [LIST_DEPTH];
  int unsigned             list_len;
  logic [CAP_W-1:0]        cap_now;

  nsl_rsp_t    pending_rsp[$];
  int unsigned errors;
  int unsigned reqs_sent;
  int unsigned rsps_seen;
  int unsigned hold_cycles;
  int unsigned rx_gap;
  bit          no_idle;
  logic [31:0] caps_used;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // apply one request to the predicted list and return the expected result
  function automatic nsl_rsp_t update_list(nsl_req_t r);
    nsl_rsp_t    rsp;
    int unsigned lim;
    int unsigned pos;
    int unsigned last;
    int          i;
    rsp = '0;
    case (r.req_type)
      REQ_INSERT: begin
        lim = (cap_now > LIST_DEPTH) ? LIST_DEPTH : cap_now;
        pos = 0;
        while (pos < list_len && $signed(list_key[pos]) >= $signed(r.new_key)) pos++;
        // full list: the new entry itself falls off when it would land last
        if (lim != 0 && (list_len < lim || pos < list_len)) begin
          if (list_len < lim) begin
            last = list_len;
            list_len++;
          end else begin
            last = list_len - 1;
          end
          for (i = last; i > pos; i--) begin
            list_key[i] = list_key[i-1];
            list_pay[i] = list_pay[i-1];
          end
          list_key[pos] = r.new_key;
          list_pay[pos] = r.new_payload;
        end
      end
      REQ_REMOVE: begin
        if (r.index < list_len) begin
          for (i = r.index; i + 1 < list_len; i++) begin
            list_key[i] = list_key[i+1];
            list_pay[i] = list_pay[i+1];
          end
          list_len--;
        end else begin
          rsp.status = 1'b1;
        end
      end
      REQ_READ: begin
        if (r.index < list_len) begin
          rsp.read_key     = list_key[r.index];
          rsp.read_payload = list_pay[r.index];
        end else begin
          rsp.status = 1'b1;
        end
      end
      default: list_len = 0;
    endcase
    rsp.count = list_len[CAP_W-1:0];
    return rsp;
  endfunction

  function automatic nsl_req_t make_req(req_t kind, logic [31:0] key, logic [31:0] pay,
                                        logic [IDX_W-1:0] idx);
    nsl_req_t r;
    r.req_type    = kind;
    r.new_key     = key;
    r.new_payload = pay;
    r.index       = idx;
    return r;
  endfunction

  function automatic logic [31:0] rand_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h8000_0000;
    if (r == 1) return 32'h7fff_ffff;
    // narrow band so equal keys turn up often
    if (r < 6) return $unsigned(32'($signed($urandom_range(0, 8)) - 4));
    return $urandom;
  endfunction

  function automatic nsl_req_t rand_req(int unsigned ins_pct);
    nsl_req_t    r;
    int unsigned pick;
    r.new_key     = rand_key();
    r.new_payload = $urandom;
    if ($urandom_range(0, 3) == 0 || list_len == 0)
      r.index = IDX_W'($urandom_range(0, LIST_DEPTH - 1));
    else
      r.index = IDX_W'($urandom_range(0, list_len - 1));
    pick = $urandom_range(0, 99);
    if (pick < ins_pct)
      r.req_type = REQ_INSERT;
    else begin
      pick = $urandom_range(0, 19);
      if (pick < 9)       r.req_type = REQ_READ;
      else if (pick < 18) r.req_type = REQ_REMOVE;
      else                r.req_type = REQ_CLEAR;
    end
    return r;
  endfunction

  // send one request; valid is only lowered when a gap precedes it
  task automatic send_req(nsl_req_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    pending_rsp.push_back(update_list(r));
    reqs_sent++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_capacity(logic [CAP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cap_now  = value;
    caps_used[value] = 1'b1;
  endtask

  task automatic test_directed();
    send_req(make_req(REQ_READ, 0, 0, 0));
    send_req(make_req(REQ_REMOVE, 0, 0, 0));
    send_req(make_req(REQ_INSERT, 32'd0, 32'h1111_1111, 0));
    send_req(make_req(REQ_INSERT, 32'd0, 32'h2222_2222, 0));
    send_req(make_req(REQ_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 4'hf));
    send_req(make_req(REQ_INSERT, 32'h8000_0000, 32'h0, 0));
    send_req(make_req(REQ_READ, 0, 0, 0));
    send_req(make_req(REQ_READ, 0, 0, 1));
    send_req(make_req(REQ_READ, 0, 0, 2));
    send_req(make_req(REQ_READ, 0, 0, 3));
    send_req(make_req(REQ_READ, 0, 0, 4'hf));
    send_req(make_req(REQ_REMOVE, 0, 0, 4'hf));
    send_req(make_req(REQ_REMOVE, 0, 0, 1));
    send_req(make_req(REQ_READ, 0, 0, 1));
    send_req(make_req(REQ_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 4'hf));
    send_req(make_req(REQ_READ, 0, 0, 0));
    wait_results();
    // two-entry list: smaller newcomer drops itself, larger one pushes out the last
    write_capacity(5'd2);
    send_req(make_req(REQ_INSERT, 32'd5, 32'hA5A5_A5A5, 0));
    send_req(make_req(REQ_INSERT, 32'd3, 32'h5A5A_5A5A, 0));
    send_req(make_req(REQ_INSERT, 32'd1, 32'h0000_0001, 0));
    send_req(make_req(REQ_INSERT, 32'd9, 32'h8000_0000, 0));
    send_req(make_req(REQ_READ, 0, 0, 0));
    send_req(make_req(REQ_READ, 0, 0, 1));
    wait_results();
    write_capacity(5'd0);
    send_req(make_req(REQ_INSERT, 32'd7, 32'h1234_5678, 0));
    send_req(make_req(REQ_READ, 0, 0, 0));
    wait_results();
  endtask

  // capacity one and above the list depth
  task automatic test_capacity_extremes();
    logic [CAP_W-1:0] caps [3];
    int               c;
    int               n;
    caps = '{5'd1, 5'd31, 5'd17};
    for (c = 0; c < 3; c++) begin
      write_capacity(caps[c]);
      for (n = 0; n < 30; n++) send_req(rand_req(70));
      wait_results();
    end
  endtask

  // capacity lowered below the number of held entries
  task automatic test_shrink();
    int n;
    write_capacity(5'd16);
    send_req(make_req(REQ_CLEAR, 0, 0, 0));
    for (n = 0; n < 14; n++) send_req(rand_req(100));
    wait_results();
    write_capacity(5'd3);
    for (n = 0; n < 18; n++) send_req(rand_req(75));
    wait_results();
  endtask

  task automatic test_random_phases();
    int p;
    int n;
    for (p = 0; p < 10; p++) begin
      write_capacity((p == 0) ? 5'd16 : 5'($urandom_range(1, LIST_DEPTH)));
      for (n = 0; n < 50; n++) send_req(rand_req(55));
      wait_results();
    end
  endtask

  task automatic test_back_to_back();
    int n;
    write_capacity(5'd8);
    no_idle = 1'b1;
    for (n = 0; n < 60; n++) send_req(rand_req(55));
    no_idle = 1'b0;
    wait_results();
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    int n;
    write_capacity(5'd16);
    hold_cycles = 60;
    for (n = 0; n < 30; n++) send_req(rand_req(60));
    wait_results();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    list_len  = 0;
    cap_now   = CAP_RESET;
    caps_used = '0;
    caps_used[CAP_RESET] = 1'b1;
    errors    = 0;
    reqs_sent = 0;
    no_idle   = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_capacity_extremes();
    test_shrink();
    test_random_phases();
    test_back_to_back();
    test_backpressure();

    wait_results();
    repeat (8) @(posedge clk);
    if (pending_rsp.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_rsp.size()));
    $display("Covered %0d requests, %0d results checked, %0d capacity settings.",
             reqs_sent, rsps_seen, $countones(caps_used));
    $display("Mismatches and protocol errors: %0d", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // result side: random stalls plus an occasional long hold-off
  initial begin
    out_ready   = 1'b0;
    hold_cycles = 0;
    rx_gap      = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ready <= 1'b1;
        rx_gap = pick_gap();
      end
    end
  end

  initial rsps_seen = 0;

  always @(posedge clk) begin : check_rsp
    nsl_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      rsps_seen++;
      if (pending_rsp.size() == 0) begin
        note_error($sformatf("result %0d arrived with nothing expected", rsps_seen));
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp.status !== want.status || out_rsp.read_key !== want.read_key ||
            out_rsp.read_payload !== want.read_payload || out_rsp.count !== want.count)
          note_error($sformatf({"result %0d mismatch: status %0b/%0b key %0d/%0d ",
                                "payload %h/%h count %0d/%0d (expected/actual)"},
                               rsps_seen, want.status, out_rsp.status,
                               $signed(want.read_key), $signed(out_rsp.read_key),
                               want.read_payload, out_rsp.read_payload,
                               want.count, out_rsp.count));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Run timed out with %0d results outstanding", pending_rsp.size());
    $display("FAILURE");
    $finish;
  end

endmodule
